// ===== rtl/bx3_pkg.sv =====
// Shared types, constants and lane arithmetic for the 3x3 box downscaler.
package bx3_pkg;

  localparam int unsigned LANE_W   = 12;
  localparam int unsigned LANES    = 4;
  localparam int unsigned SUM_W    = LANE_W * LANES;
  localparam int unsigned CH_W     = 8;
  localparam int unsigned COL_W    = 10;
  localparam int unsigned ROW_W    = 10;
  localparam int unsigned WIDTH_W  = 10;
  localparam int unsigned HEIGHT_W = 11;
  localparam int unsigned GRP_W    = 9;   // block column index, up to 1022/3
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [HEIGHT_W-1:0] ROW_LIMIT = 11'd1024;

  // floor(v/9) for v < 4096 as (v * 14564) >> 17
  localparam int unsigned RECIP_W     = 15;
  localparam logic [RECIP_W-1:0] RECIP9 = 15'd14564;
  localparam int unsigned RECIP_SHIFT = 17;

  // position within a block, column or row
  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_LAST  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  typedef logic [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic             active;  // pixel lies in a kept block
    logic             last;    // block is the last one of the frame
    logic [1:0]       col_ph;
    logic [1:0]       row_ph;
    logic [GRP_W-1:0] grp;
  } pos_t;

  function automatic sum_t lane_add(sum_t a, sum_t b);
    sum_t r;
    for (int c = 0; c < LANES; c++) begin
      r[c*LANE_W +: LANE_W] = a[c*LANE_W +: LANE_W] + b[c*LANE_W +: LANE_W];
    end
    return r;
  endfunction

  function automatic logic [CH_W-1:0] div9_sat(logic [LANE_W-1:0] v);
    logic [LANE_W+RECIP_W-1:0] p;
    logic [LANE_W+RECIP_W-RECIP_SHIFT-1:0] q;
    p = (LANE_W+RECIP_W)'(v) * (LANE_W+RECIP_W)'(RECIP9);
    q = p[LANE_W+RECIP_W-1:RECIP_SHIFT];
    return (q > (LANE_W+RECIP_W-RECIP_SHIFT)'(255)) ? 8'hFF : q[CH_W-1:0];
  endfunction

endpackage

// ===== rtl/bx3_line_store.sv =====
// Line store of per-block-column partial sums: one write port, one registered read port.
module bx3_line_store #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                clk_i,
  input  logic                re_i,
  input  logic [AW-1:0]       raddr_i,
  output bx3_pkg::sum_t       rdata_o,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  bx3_pkg::sum_t       wdata_i
);

  bx3_pkg::sum_t mem [DEPTH];
  bx3_pkg::sum_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bx3_pos_ctrl.sv =====
// Raster position counters and block classification of the next input pixel.
module bx3_pos_ctrl #(
  parameter int unsigned MAX_OUT_COLUMNS = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            adv_i,
  input  logic [bx3_pkg::WIDTH_W-1:0]     width_i,
  input  logic [bx3_pkg::HEIGHT_W-1:0]    height_i,
  output bx3_pkg::pos_t                   pos_o
);

  localparam int unsigned CW = bx3_pkg::COL_W + 1;
  localparam int unsigned RW = bx3_pkg::HEIGHT_W + 1;

  logic [bx3_pkg::COL_W-1:0]    col_q, col_d;
  logic [bx3_pkg::ROW_W-1:0]    row_q, row_d;
  logic [1:0]                   col_ph_q, col_ph_d, row_ph_q, row_ph_d;
  logic [bx3_pkg::GRP_W-1:0]    grp_q, grp_d;

  logic [bx3_pkg::WIDTH_W-1:0]  eff_w;
  logic [bx3_pkg::HEIGHT_W-1:0] eff_h;
  logic [CW-1:0]                col_start;
  logic [RW-1:0]                row_start;
  logic                         grp_kept, grp_final, col_act, row_act, col_end, row_end;

  always_comb begin
    eff_w = (width_i == '0) ? bx3_pkg::WIDTH_W'(1) : width_i;
    if (height_i == '0) begin
      eff_h = bx3_pkg::HEIGHT_W'(1);
    end else if (height_i > bx3_pkg::ROW_LIMIT) begin
      eff_h = bx3_pkg::ROW_LIMIT;
    end else begin
      eff_h = height_i;
    end
  end

  // first column and row of the current block
  assign col_start = CW'(col_q) - CW'(col_ph_q);
  assign row_start = RW'(row_q) - RW'(row_ph_q);

  assign grp_kept  = 11'(grp_q) < 11'(MAX_OUT_COLUMNS);
  assign grp_final = 11'(grp_q) == 11'(MAX_OUT_COLUMNS - 1);
  assign col_act   = (col_start + CW'(3) <= CW'(eff_w)) && grp_kept;
  assign row_act   = (row_start + RW'(3) <= RW'(eff_h));
  assign col_end   = (col_start + CW'(6) > CW'(eff_w)) || grp_final;
  assign row_end   = (row_start + RW'(6) > RW'(eff_h));

  always_comb begin
    pos_o.active = col_act && row_act;
    pos_o.last   = col_end && row_end;
    pos_o.col_ph = col_ph_q;
    pos_o.row_ph = row_ph_q;
    pos_o.grp    = grp_q;
  end

  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    col_ph_d = col_ph_q;
    row_ph_d = row_ph_q;
    grp_d    = grp_q;
    if (adv_i) begin
      if (CW'(col_q) + CW'(1) >= CW'(eff_w)) begin
        col_d    = '0;
        col_ph_d = bx3_pkg::PH_FIRST;
        grp_d    = '0;
        if (RW'(row_q) + RW'(1) >= RW'(eff_h)) begin
          row_d    = '0;
          row_ph_d = bx3_pkg::PH_FIRST;
        end else begin
          row_d    = row_q + bx3_pkg::ROW_W'(1);
          row_ph_d = (row_ph_q >= bx3_pkg::PH_LAST) ? bx3_pkg::PH_FIRST : row_ph_q + 2'd1;
        end
      end else begin
        col_d = col_q + bx3_pkg::COL_W'(1);
        if (col_ph_q >= bx3_pkg::PH_LAST) begin
          col_ph_d = bx3_pkg::PH_FIRST;
          grp_d    = grp_q + bx3_pkg::GRP_W'(1);
        end else begin
          col_ph_d = col_ph_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      col_ph_q <= bx3_pkg::PH_FIRST;
      row_ph_q <= bx3_pkg::PH_FIRST;
      grp_q    <= '0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      col_ph_q <= col_ph_d;
      row_ph_q <= row_ph_d;
      grp_q    <= grp_d;
    end
  end

endmodule

// ===== rtl/box3x3_rgba_downscale_core.sv =====
// Top level of the 3x3 box-filter RGBA downscaler.
//
//  channel   | direction | transaction carries
//  ----------+-----------+---------------------------------------------------
//  s_axis    | in        | one RGBA8888 pixel in raster order
//  m_axis    | out       | one averaged pixel, tlast on the frame's last one
//  cfg       | in        | write of frame_width (index 0) or frame_height (1)
//
// One pixel per cycle sustained while the output is not stalled. A pixel
// goes through the position stage (horizontal sum, line-store read) into
// the column-stage register; the column stage then does the line-store
// add/write back or the divide into the output register. Output stalls
// hold the column stage and then the input. Reset clears the counters and
// the horizontal sum; the line store is not cleared and needs no sweep.
module box3x3_rgba_downscale_core #(
  parameter int unsigned MAX_OUT_COLUMNS = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [31:0]                       s_axis_tdata,   // red, green, blue, alpha
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [31:0]                       m_axis_tdata,   // out_red, out_green, out_blue, out_alpha
  output logic                              m_axis_tlast,   // frame_last
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bx3_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bx3_pkg::HEIGHT_W-1:0]      cfg_data_i
);

  localparam int unsigned AW = (MAX_OUT_COLUMNS > 1) ? $clog2(MAX_OUT_COLUMNS) : 1;
  localparam int unsigned LW = bx3_pkg::LANE_W;
  localparam int unsigned CW = bx3_pkg::CH_W;

  // configuration
  logic [bx3_pkg::WIDTH_W-1:0]  width_q;
  logic [bx3_pkg::HEIGHT_W-1:0] height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bx3_pkg::WIDTH_W'(512);
      height_q <= bx3_pkg::HEIGHT_W'(448);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bx3_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_data_i[bx3_pkg::WIDTH_W-1:0];
        bx3_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // position stage
  bx3_pkg::pos_t pos;
  logic          in_acc;
  logic [AW-1:0] grp_addr;
  bx3_pkg::sum_t pix, hs_q, hs_d;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  bx3_pos_ctrl #(
    .MAX_OUT_COLUMNS(MAX_OUT_COLUMNS)
  ) u_pos (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (in_acc),
    .width_i  (width_q),
    .height_i (height_q),
    .pos_o    (pos)
  );

  // kept groups always fit the store address
  assign grp_addr = AW'(pos.grp);

  always_comb begin
    for (int c = 0; c < bx3_pkg::LANES; c++) begin
      pix[c*LW +: LW] = LW'(s_axis_tdata[c*CW +: CW]);
    end
    hs_d = bx3_pkg::lane_add((pos.col_ph == bx3_pkg::PH_FIRST) ? '0 : hs_q, pix);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hs_q <= '0;
    end else if (in_acc && pos.active) begin
      hs_q <= hs_d;
    end
  end

  // column stage
  logic          s1_valid_q, s1_valid_d;
  logic          s1_mem_q, s1_emit_q, s1_last_q;
  logic [AW-1:0] s1_addr_q;
  bx3_pkg::sum_t s1_hs_q, cs, rd_data;
  logic          s1_load, s1_adv, mem_re, mem_we;

  assign s1_load = in_acc && pos.active && (pos.col_ph == bx3_pkg::PH_LAST);
  assign mem_re  = s1_load && (pos.row_ph != bx3_pkg::PH_FIRST);
  assign s1_adv  = s1_valid_q && (!s1_emit_q || !m_axis_tvalid || m_axis_tready);
  assign mem_we  = s1_adv && !s1_emit_q;
  assign s_axis_tready = !s1_valid_q || s1_adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_load) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_hs_q   <= hs_d;
      s1_mem_q  <= (pos.row_ph != bx3_pkg::PH_FIRST);
      s1_emit_q <= (pos.row_ph == bx3_pkg::PH_LAST);
      s1_last_q <= pos.last;
      s1_addr_q <= grp_addr;
    end
  end

  bx3_line_store #(
    .DEPTH(MAX_OUT_COLUMNS),
    .AW   (AW)
  ) u_store (
    .clk_i   (clk_i),
    .re_i    (mem_re),
    .raddr_i (grp_addr),
    .rdata_o (rd_data),
    .we_i    (mem_we),
    .waddr_i (s1_addr_q),
    .wdata_i (cs)
  );

  assign cs = s1_mem_q ? bx3_pkg::lane_add(rd_data, s1_hs_q) : s1_hs_q;

  // output register
  logic        m_valid_q, m_valid_d, m_load;
  logic [31:0] m_data_q, m_data_d;
  logic        m_last_q;

  assign m_load = s1_adv && s1_emit_q;

  always_comb begin
    for (int c = 0; c < bx3_pkg::LANES; c++) begin
      m_data_d[c*CW +: CW] = bx3_pkg::div9_sat(cs[c*LW +: LW]);
    end
    m_valid_d = m_valid_q;
    if (m_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_load) begin
      m_data_q <= m_data_d;
      m_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  // checks
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re && mem_we |-> grp_addr != s1_addr_q)
    else $error("line store read and write hit the same entry");

  a_stall_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> s1_valid_q && s1_emit_q && m_axis_tvalid)
    else $error("input stalled without a pending result");

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s1_valid_q && s1_emit_q))
    else $error("result raised without an emitting column stage");

endmodule
